// ===== rtl/core/mcvr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcvr_pkg
// shared types and constants for the matrix chain vector reduce block
// ----------------------------------------------------------------------------
package mcvr_pkg;

  localparam int unsigned OP_W = 2;
  localparam int unsigned IDX_W = 5;
  localparam int unsigned DIM_W = 6;
  localparam int unsigned RES_W = 64;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_LOAD_C  = 2'd2,
    OP_COMPUTE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT,
    ST_SUM
  } state_t;

  localparam logic [RES_W-1:0] S64_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] S64_MIN = {1'b1, {(RES_W-1){1'b0}}};

  // saturating 64-bit signed add
  function automatic logic [RES_W-1:0] sat_add(input logic [RES_W-1:0] a,
                                              input logic [RES_W-1:0] b);
    logic [RES_W-1:0] s;
    s = a + b;
    if (!a[RES_W-1] && !b[RES_W-1] && s[RES_W-1]) return S64_MAX;
    if (a[RES_W-1] && b[RES_W-1] && !s[RES_W-1]) return S64_MIN;
    return s;
  endfunction

endpackage

// ===== rtl/core/mcvr_if.sv =====
// ----------------------------------------------------------------------------
// mcvr_in_if / mcvr_out_if / mcvr_cfg_if
// valid-ready channels of the block
// ----------------------------------------------------------------------------
interface mcvr_in_if #(parameter int VALUE_BITS = 16);
  logic valid;
  logic ready;
  logic [1:0] op;
  logic [4:0] row;
  logic [4:0] col;
  logic signed [VALUE_BITS-1:0] value;
  modport source (output valid, op, row, col, value, input ready);
  modport sink (input valid, op, row, col, value, output ready);
endinterface

interface mcvr_out_if;
  logic valid;
  logic ready;
  logic kind;
  logic [4:0] index;
  logic signed [63:0] result;
  logic last;
  modport source (output valid, kind, index, result, last, input ready);
  modport sink (input valid, kind, index, result, last, output ready);
endinterface

interface mcvr_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [5:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mcvr_cell.sv =====
// ----------------------------------------------------------------------------
// mcvr_cell
// one cell of the chain: holds one row of b, forms a*b products and passes
// the partial ab sum to its neighbor
// ----------------------------------------------------------------------------
module mcvr_cell #(
  parameter int VALUE_BITS = 16,
  parameter int MAX_DIM = 32,
  parameter int ACC_W = 2 * VALUE_BITS + 6
) (
  input  logic                          clk,
  input  logic                          b_we,
  input  logic [$clog2(MAX_DIM+1)-1:0]  b_col_wr,
  input  logic signed [VALUE_BITS-1:0]  b_wdata,
  input  logic [$clog2(MAX_DIM+1)-1:0]  b_col_rd,
  input  logic                          active,
  input  logic signed [VALUE_BITS-1:0]  a_in,
  input  logic signed [ACC_W-1:0]       sum_in,
  output logic signed [ACC_W-1:0]       sum_out
);
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  logic signed [VALUE_BITS-1:0] row_mem [MAX_DIM];
  logic signed [VALUE_BITS-1:0] b_rd_r;
  logic signed [2*VALUE_BITS-1:0] prod;

  always_ff @(posedge clk) begin
    if (b_we) row_mem[b_col_wr[IW-1:0]] <= b_wdata;
    b_rd_r <= row_mem[b_col_rd[IW-1:0]];
  end

  assign prod = a_in * b_rd_r;

  always_ff @(posedge clk) begin
    sum_out <= sum_in + (active ? ACC_W'(prod) : '0);
  end
endmodule

// ===== rtl/core/matrix_chain_vector_reduce.sv =====
// order: a compute request walks all rows and columns of ab before the
//   first d element, then one result per cycle while out_ch.ready is high
// throughput: loads one per cycle while idle; compute is set by the walk over rows and
//   columns, each ab element sliding down a chain of inner cells
// reset: synchronous active-low rst_n clears control and sets dims to 1;
//   the element stores hold undefined data until loaded
// ----------------------------------------------------------------------------
// matrix_chain_vector_reduce
// computes d = (a*b)*c with a chain of multiply-accumulate cells and emits
// every d element followed by the saturated sum
// ----------------------------------------------------------------------------
module matrix_chain_vector_reduce #(
  parameter int MAX_DIM = 32,
  parameter int VALUE_BITS = 16
) (
  input logic clk,
  input logic rst_n,
  mcvr_in_if.sink   in_ch,
  mcvr_out_if.source out_ch,
  mcvr_cfg_if.sink  cfg_ch
);
  localparam int CW = $clog2(MAX_DIM+1);
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1;
  localparam int ACC_W = 2 * VALUE_BITS + 6;
  localparam int RES_W = mcvr_pkg::RES_W;

  // configuration registers
  logic [5:0] rows_r, inner_r, cols_r;
  logic [CW:0] ny, nw, nv;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 6'd1; inner_r <= 6'd1; cols_r <= 6'd1;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (mcvr_pkg::cfg_idx_t'(cfg_ch.index))
        mcvr_pkg::CFG_ROWS_A:    rows_r <= cfg_ch.data;
        mcvr_pkg::CFG_INNER_DIM: inner_r <= cfg_ch.data;
        mcvr_pkg::CFG_COLS_B:    cols_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end
  assign cfg_ch.ready = 1'b1;
  // values above the store size act as the store size
  assign ny = ({1'b0, rows_r}  > (CW+1)'(MAX_DIM)) ? (CW+1)'(MAX_DIM) : (CW+1)'(rows_r);
  assign nw = ({1'b0, inner_r} > (CW+1)'(MAX_DIM)) ? (CW+1)'(MAX_DIM) : (CW+1)'(inner_r);
  assign nv = ({1'b0, cols_r}  > (CW+1)'(MAX_DIM)) ? (CW+1)'(MAX_DIM) : (CW+1)'(cols_r);

  mcvr_pkg::state_t state_r, state_nxt;
  logic in_fire, out_fire;
  logic in_row_ok, in_col_ok;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_row_ok = {1'b0, in_ch.row} < 6'(MAX_DIM);
  assign in_col_ok = {1'b0, in_ch.col} < 6'(MAX_DIM);

  // a: one flat memory indexed row*MAX_DIM+col, read row-wise into the cells; c vector small array
  logic signed [VALUE_BITS-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic signed [VALUE_BITS-1:0] c_mem [MAX_DIM];
  logic signed [RES_W-1:0] d_mem [MAX_DIM];

  // walk counters
  logic [CW-1:0] i_r, i_nxt;   // row of a
  logic [CW-1:0] j_r, j_nxt;   // column of b
  logic [CW-1:0] k_r, k_nxt;   // cell being fed (skewed feed)
  logic [CW:0]   wait_r, wait_nxt;
  logic [CW-1:0] e_r, e_nxt;   // emit index
  logic feeding;

  // a element fed into cell k this cycle: read registered from a_mem
  logic signed [VALUE_BITS-1:0] a_rd_r;
  logic a_valid_r;
  logic [CW-1:0] a_k_r;

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.op == mcvr_pkg::OP_LOAD_A && in_row_ok && in_col_ok)
      a_mem[AW'(in_ch.row * MAX_DIM + in_ch.col)] <= in_ch.value;
    if (in_fire && in_ch.op == mcvr_pkg::OP_LOAD_C && in_row_ok)
      c_mem[IW'(in_ch.row)] <= in_ch.value;
    a_rd_r <= a_mem[AW'(i_r * MAX_DIM + k_r)];
  end

  // the chain: cell k holds row k of b; partial ab moves one cell per cycle.
  // one ab element at a time: feed a[i][k] to cell k at step k
  logic signed [ACC_W-1:0] chain [MAX_DIM+1];
  logic [MAX_DIM-1:0] cell_act;
  assign chain[0] = '0;
  genvar g;
  generate
    for (g = 0; g < MAX_DIM; g++) begin : g_cell
      logic bwe;
      assign bwe = in_fire && in_ch.op == mcvr_pkg::OP_LOAD_B && in_row_ok && in_col_ok
                   && CW'(in_ch.row) == CW'(g);
      assign cell_act[g] = a_valid_r && a_k_r == CW'(g);
      mcvr_cell #(.VALUE_BITS(VALUE_BITS), .MAX_DIM(MAX_DIM), .ACC_W(ACC_W)) u_cell (
        .clk(clk), .b_we(bwe), .b_col_wr(CW'(in_ch.col)), .b_wdata(in_ch.value),
        .b_col_rd(j_r), .active(cell_act[g]), .a_in(a_rd_r),
        .sum_in(chain[g]), .sum_out(chain[g+1])
      );
    end
  endgenerate

  // ab tap: sum leaves cell nw-1; with nw cells it arrives at chain[nw]
  logic signed [ACC_W-1:0] ab_tap;
  assign ab_tap = chain[nw[CW-1:0]];

  // column-level: ab * c, registered, then saturating add into d
  logic signed [VALUE_BITS-1:0] c_rd_r;
  logic signed [RES_W-1:0] prod_r, d_r, sum_r;
  logic prod_v_r, ab_v;
  always_ff @(posedge clk) begin
    c_rd_r <= c_mem[IW'(j_r)];
    prod_r <= RES_W'(ab_tap) * RES_W'(c_rd_r);
  end

  // control: ab elements are formed one at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcvr_pkg::ST_IDLE;
      i_r <= '0; j_r <= '0; k_r <= '0; wait_r <= '0; e_r <= '0;
      a_valid_r <= 1'b0; prod_v_r <= 1'b0;
      d_r <= '0; sum_r <= '0;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt; wait_r <= wait_nxt; e_r <= e_nxt;
      a_valid_r <= feeding;
      prod_v_r <= ab_v;
      if (state_r == mcvr_pkg::ST_IDLE) begin
        d_r <= '0; sum_r <= '0;
      end else if (prod_v_r) begin
        if (j_r == '0) begin
          // column counter wrapped: last column of the row finishes d
          d_mem[IW'(i_r - 1'b1)] <= mcvr_pkg::sat_add(d_r, prod_r);
          sum_r <= mcvr_pkg::sat_add(sum_r, mcvr_pkg::sat_add(d_r, prod_r));
          d_r <= '0;
        end else begin
          d_r <= mcvr_pkg::sat_add(d_r, prod_r);
        end
      end
    end
  end
  always_ff @(posedge clk) begin
    a_k_r <= k_r;
  end

  logic signed [RES_W-1:0] d_rd;
  assign d_rd = d_mem[IW'(e_r)];

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r; wait_nxt = wait_r; e_nxt = e_r;
    feeding = 1'b0; ab_v = 1'b0;
    in_ch.ready = (state_r == mcvr_pkg::ST_IDLE);
    out_ch.valid = 1'b0; out_ch.kind = 1'b0; out_ch.index = '0;
    out_ch.result = d_rd; out_ch.last = 1'b0;
    case (state_r)
      mcvr_pkg::ST_IDLE: begin
        // ready is high here, so valid alone accepts the request
        if (in_ch.valid && in_ch.op == mcvr_pkg::OP_COMPUTE) begin
          i_nxt = '0; j_nxt = '0; k_nxt = '0; e_nxt = '0;
          wait_nxt = (CW+1)'(nw) + (CW+1)'(2);
          if (ny == '0) state_nxt = mcvr_pkg::ST_SUM;
          else if (nv == '0 || nw == '0) state_nxt = mcvr_pkg::ST_EMIT;
          else state_nxt = mcvr_pkg::ST_RUN;
        end
      end
      mcvr_pkg::ST_RUN: begin
        // feed a[i][k] while k < nw; product comes out after the chain
        feeding = (CW+1)'(k_r) < nw && wait_r > (CW+1)'(2);
        if (feeding) k_nxt = k_r + 1'b1;
        wait_nxt = wait_r - 1'b1;
        if (wait_r == (CW+1)'(1)) ab_v = 1'b1;
        if (wait_r == (CW+1)'(1)) begin
          k_nxt = '0;
          wait_nxt = (CW+1)'(nw) + (CW+1)'(2);
          if ((CW+1)'(j_r) + 1'b1 == nv) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
            if ((CW+1)'(i_r) + 1'b1 == ny) begin
              state_nxt = mcvr_pkg::ST_EMIT;
              wait_nxt = (CW+1)'(2);
            end
          end else j_nxt = j_r + 1'b1;
        end
      end
      mcvr_pkg::ST_EMIT: begin
        if (wait_r != '0) wait_nxt = wait_r - 1'b1;
        else begin
          out_ch.valid = 1'b1;
          out_ch.index = 5'(e_r);
          out_ch.result = (nv == '0 || nw == '0) ? '0 : d_rd;
          if (out_ch.ready) begin
            e_nxt = e_r + 1'b1;
            if ((CW+1)'(e_r) + 1'b1 == ny) state_nxt = mcvr_pkg::ST_SUM;
          end
        end
      end
      mcvr_pkg::ST_SUM: begin
        out_ch.valid = 1'b1; out_ch.kind = 1'b1; out_ch.last = 1'b1;
        out_ch.result = sum_r;
        if (out_ch.ready) state_nxt = mcvr_pkg::ST_IDLE;
      end
      default: state_nxt = mcvr_pkg::ST_IDLE;
    endcase
  end

  // the block never offers a result while it takes requests
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready with output valid");
  a_last_is_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.last == out_ch.kind)) else $error("last without sum");
  a_sum_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_ch.last) |=> in_ch.ready) else $error("no return to idle");
endmodule
